// ===== hdl/peqb_pkg.sv =====
// shared constants and codes for the prioritized event queue bank
// no dependencies
`default_nettype none

package peqb_pkg;

  localparam int ACTORS          = 8;
  localparam int ACTOR_W         = 3;
  localparam int EVENT_W         = 32;
  localparam int CFG_W           = 5;
  localparam int COUNT_OUT_W     = 5;
  localparam int PEND_W          = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CAP_RESET       = 16;

  typedef enum logic [1:0] {
    ACT_POST   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/peqb_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module peqb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/prioritized_event_queue_bank.sv =====
// per-actor circular event queues with a pending bitmap, all held in one shared ram
// depends on peqb_pkg and peqb_ram
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tuser: action; tdata: actor, event_req
// out_     out  out_tvalid/out_tready  tuser: status; tdata: event, actor, count, mask
// cfg_     in   cfg_valid/cfg_ready    cfg_data: queue_capacity
//
// post, insert and a take with nothing pending go from S_EXEC straight to S_FINISH; a take
// passes S_RDWAIT, remove walks S_WALK: one entry read per cycle, then the last compare drains
// one request at a time; in_tready is high only while the sequencer is idle, so a request
// holds the input until the result of the one before has gone into the output register
// a stalled result holds in the output register; a new request may be taken meanwhile
// rst_n is synchronous; queues come out empty, capacity 16, no clearing pass
`default_nettype none

module prioritized_event_queue_bank #(
  parameter int QUEUE_DEPTH = peqb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [39:0]                    in_tdata,  // actor, event_req, zero fill
  input  wire logic [1:0]                     in_tuser,  // action
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [47:0]                    out_tdata, // event_out, actor_out, entry_count,
                                                         // pending_mask
  output logic      [1:0]                     out_tuser, // status
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [peqb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW        = PTR_W + 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int AW        = peqb_pkg::ACTOR_W;
  localparam int ADDR_W    = AW + PTR_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int EW        = peqb_pkg::EVENT_W;
  localparam int NA        = peqb_pkg::ACTORS;
  localparam int CAP_RST   = (peqb_pkg::CAP_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH
                                                                 : peqb_pkg::CAP_RESET;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  function automatic logic [PTR_W-1:0] ptr_fwd(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [NW-1:0] n;
    n = {1'b0, p} + 1'b1;
    if (n >= NW'(cap) || n >= NW'(QUEUE_DEPTH)) begin
      ptr_fwd = '0;
    end else begin
      ptr_fwd = n[PTR_W-1:0];
    end
  endfunction

  function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] cm1;
    cm1 = cap - 1'b1;
    if (p == '0) begin
      ptr_back = PTR_W'(cm1);
    end else begin
      ptr_back = p - 1'b1;
    end
  endfunction

  state_t            state_r, state_nxt;
  peqb_pkg::action_t action_r, action_nxt;
  logic [AW-1:0]     actor_r, actor_nxt;
  logic [EW-1:0]     evt_r, evt_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [PTR_W-1:0]  head_r [NA];
  logic [PTR_W-1:0]  head_nxt [NA];
  logic [PTR_W-1:0]  tail_r [NA];
  logic [PTR_W-1:0]  tail_nxt [NA];
  logic [CNT_W-1:0]  cnt_r [NA];
  logic [CNT_W-1:0]  cnt_nxt [NA];
  logic [NA-1:0]     pend_r, pend_nxt;

  logic [EW-1:0]     res_evt_r, res_evt_nxt;
  logic [AW-1:0]     res_actor_r, res_actor_nxt;
  peqb_pkg::status_t res_status_r, res_status_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic [PTR_W-1:0]  walk_p_r, walk_p_nxt;
  logic [CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [PTR_W-1:0]  cmp_ptr_r, cmp_ptr_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [EW-1:0]               out_evt_r, out_evt_nxt;
  logic [AW-1:0]               out_actor_r, out_actor_nxt;
  peqb_pkg::status_t           out_status_r, out_status_nxt;
  logic [peqb_pkg::COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [peqb_pkg::PEND_W-1:0] out_pend_r, out_pend_nxt;

  logic [AW-1:0]     take_idx;
  logic [AW-1:0]     act;
  logic [PTR_W-1:0]  h, t, hb;
  logic [CNT_W-1:0]  c, cdec;
  logic              full;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [EW-1:0]     ram_rdata;

  peqb_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // lowest-numbered pending actor
  always_comb begin
    take_idx = '0;
    for (int i = NA - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        take_idx = AW'(i);
      end
    end
  end

  assign act  = (action_r == peqb_pkg::ACT_TAKE) ? take_idx : actor_r;
  assign h    = head_r[act];
  assign t    = tail_r[act];
  assign c    = cnt_r[act];
  assign hb   = ptr_back(h, cap_r);
  assign cdec = (c != '0) ? c - 1'b1 : '0;
  assign full = (c >= cap_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_pend_r, out_cnt_r, out_actor_r, out_evt_r};

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    actor_nxt      = actor_r;
    evt_nxt        = evt_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    res_evt_nxt    = res_evt_r;
    res_actor_nxt  = res_actor_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;
    walk_p_nxt     = walk_p_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_ptr_nxt    = cmp_ptr_r;
    out_valid_nxt  = out_valid_r;
    out_evt_nxt    = out_evt_r;
    out_actor_nxt  = out_actor_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_pend_nxt   = out_pend_r;
    ram_we         = 1'b0;
    ram_waddr      = {act, t};
    ram_wdata      = evt_r;
    ram_raddr      = {act, h};

    if (cfg_valid) begin
      if (cfg_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (32'(cfg_data) > 32'(QUEUE_DEPTH)) begin
        cap_nxt = CNT_W'(QUEUE_DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_data);
      end
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          action_nxt = peqb_pkg::action_t'(in_tuser);
          actor_nxt  = in_tdata[AW-1:0];
          evt_nxt    = in_tdata[AW+EW-1:AW];
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        res_evt_nxt    = '0;
        res_actor_nxt  = act;
        res_status_nxt = peqb_pkg::ST_OK;
        res_cnt_nxt    = c;
        state_nxt      = S_FINISH;
        case (action_r)
          peqb_pkg::ACT_POST: begin
            if (full) begin
              res_status_nxt = peqb_pkg::ST_FULL;
            end else begin
              ram_we        = 1'b1;
              ram_waddr     = {act, t};
              tail_nxt[act] = ptr_fwd(t, cap_r);
              cnt_nxt[act]  = c + 1'b1;
              pend_nxt[act] = 1'b1;
              res_cnt_nxt   = c + 1'b1;
            end
          end
          peqb_pkg::ACT_INSERT: begin
            ram_we        = 1'b1;
            ram_waddr     = {act, hb};
            head_nxt[act] = hb;
            pend_nxt[act] = 1'b1;
            if (full) begin
              tail_nxt[act]  = ptr_back(t, cap_r);
              res_status_nxt = peqb_pkg::ST_DROPPED;
            end else begin
              cnt_nxt[act] = c + 1'b1;
              res_cnt_nxt  = c + 1'b1;
            end
          end
          peqb_pkg::ACT_TAKE: begin
            if (pend_r == '0) begin
              res_status_nxt = peqb_pkg::ST_EMPTY;
              res_actor_nxt  = '0;
              res_cnt_nxt    = '0;
            end else begin
              ram_raddr     = {act, h};
              head_nxt[act] = ptr_fwd(h, cap_r);
              cnt_nxt[act]  = cdec;
              res_cnt_nxt   = cdec;
              if (cdec == '0) begin
                pend_nxt[act] = 1'b0;
              end
              state_nxt = S_RDWAIT;
            end
          end
          peqb_pkg::ACT_REMOVE: begin
            walk_p_nxt = h;
            rd_cnt_nxt = '0;
            cmp_v_nxt  = 1'b0;
            state_nxt  = S_WALK;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_RDWAIT: begin
        res_evt_nxt = ram_rdata;
        state_nxt   = S_FINISH;
      end
      S_WALK: begin
        // compare the entry read last cycle while the next read goes out
        if (cmp_v_r && ram_rdata == evt_r) begin
          ram_we    = 1'b1;
          ram_waddr = {actor_r, cmp_ptr_r};
          ram_wdata = '0;
        end
        if (rd_cnt_r < cnt_r[actor_r]) begin
          ram_raddr   = {actor_r, walk_p_r};
          cmp_ptr_nxt = walk_p_r;
          cmp_v_nxt   = 1'b1;
          walk_p_nxt  = ptr_fwd(walk_p_r, cap_r);
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_evt_nxt    = res_evt_r;
          out_actor_nxt  = res_actor_r;
          out_status_nxt = res_status_r;
          out_cnt_nxt    = peqb_pkg::COUNT_OUT_W'(res_cnt_r);
          out_pend_nxt   = peqb_pkg::PEND_W'(pend_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CNT_W'(CAP_RST);
      pend_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      pend_r      <= pend_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    actor_r      <= actor_nxt;
    evt_r        <= evt_nxt;
    res_evt_r    <= res_evt_nxt;
    res_actor_r  <= res_actor_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
    walk_p_r     <= walk_p_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    cmp_ptr_r    <= cmp_ptr_nxt;
    out_evt_r    <= out_evt_nxt;
    out_actor_r  <= out_actor_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_pend_r   <= out_pend_nxt;
  end

  logic [NA-1:0] nonempty;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      nonempty[i] = (cnt_r[i] != '0);
    end
  end

  a_pend_matches_counts: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == nonempty)
    else $error("pending bitmap out of step with queue counts");

  a_cap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (32'(cap_r) <= 32'(QUEUE_DEPTH)))
    else $error("effective capacity out of range");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rd_cnt_r <= cnt_r[actor_r]))
    else $error("remove walk read past the held entries");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire

// ===== bench/tb_prioritized_event_queue_bank.sv =====
// self-checking bench for prioritized_event_queue_bank: a shadow queue bank predicts every result
// driver and monitor are clocked always blocks, the driver fed by a request backlog; depends on peqb_pkg
`timescale 1ns / 1ps

module tb_prioritized_event_queue_bank;

  typedef struct {
    peqb_pkg::action_t act;
    logic [2:0]        actor;
    logic [31:0]       evt;
  } request_t;

  typedef struct {
    logic [31:0]       ev;
    logic [2:0]        actor;
    peqb_pkg::status_t status;
    logic [4:0]        count;
    logic [7:0]        mask;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // actor, event_req, zero fill
  logic [1:0]  in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // event_out, actor_out, entry_count, pending_mask
  logic [1:0]  out_tuser;  // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  // shadow copy of the bank
  logic [31:0] slot_mem [peqb_pkg::ACTORS][peqb_pkg::QUEUE_DEPTH_DEF];
  logic [3:0]  head_ptr [peqb_pkg::ACTORS];
  logic [3:0]  tail_ptr [peqb_pkg::ACTORS];
  logic [4:0]  held_count [peqb_pkg::ACTORS];
  logic [7:0]  pending_set;
  logic [4:0]  capacity_reg;

  request_t request_backlog[$];
  result_t  expected_results[$];
  int       requests_driven;
  int       requests_accepted;
  int       mismatch_count;
  int       burst_left;
  int       gap_left;
  int       stall_left;
  int       stall_mode;

  prioritized_event_queue_bank DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL prioritized_event_queue_bank");
    $finish;
  end

  function automatic int effective_capacity(input logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (int'(raw) > peqb_pkg::QUEUE_DEPTH_DEF) return peqb_pkg::QUEUE_DEPTH_DEF;
    return int'(raw);
  endfunction

  function automatic logic [3:0] next_slot(input logic [3:0] p, input int cap);
    int n;
    n = int'(p) + 1;
    if (n >= cap || n >= peqb_pkg::QUEUE_DEPTH_DEF) n = 0;
    return n[3:0];
  endfunction

  function automatic logic [3:0] prev_slot(input logic [3:0] p, input int cap);
    int n;
    if (p == 4'd0) n = cap - 1;
    else n = int'(p) - 1;
    return n[3:0];
  endfunction

  // apply one request to the shadow bank and record the result it must produce
  task automatic advance_queue_bank(input peqb_pkg::action_t act, input logic [2:0] who,
                                    input logic [31:0] evt);
    result_t res;
    int      cap;
    int      a;
    int      i;
    logic [3:0] p;
    cap        = effective_capacity(capacity_reg);
    res.ev     = '0;
    res.actor  = who;
    res.status = peqb_pkg::ST_OK;
    res.count  = '0;
    case (act)
      peqb_pkg::ACT_TAKE: begin
        a = 0;
        while (a < peqb_pkg::ACTORS && !pending_set[a]) a++;
        if (a == peqb_pkg::ACTORS) begin
          res.status = peqb_pkg::ST_EMPTY;
          res.actor  = '0;
        end else begin
          res.ev = slot_mem[a][head_ptr[a]];
          head_ptr[a] = next_slot(head_ptr[a], cap);
          if (held_count[a] > 0) held_count[a]--;
          if (held_count[a] == 0) pending_set[a] = 1'b0;
          res.actor = a[2:0];
          res.count = held_count[a];
        end
      end
      peqb_pkg::ACT_POST: begin
        if (held_count[who] >= cap) begin
          res.status = peqb_pkg::ST_FULL;
        end else begin
          slot_mem[who][tail_ptr[who]] = evt;
          tail_ptr[who] = next_slot(tail_ptr[who], cap);
          held_count[who]++;
          pending_set[who] = 1'b1;
        end
        res.count = held_count[who];
      end
      peqb_pkg::ACT_INSERT: begin
        head_ptr[who] = prev_slot(head_ptr[who], cap);
        slot_mem[who][head_ptr[who]] = evt;
        if (held_count[who] >= cap) begin
          tail_ptr[who] = prev_slot(tail_ptr[who], cap);
          res.status = peqb_pkg::ST_DROPPED;
        end else begin
          held_count[who]++;
        end
        pending_set[who] = 1'b1;
        res.count = held_count[who];
      end
      default: begin
        p = head_ptr[who];
        for (i = 0; i < held_count[who]; i++) begin
          if (slot_mem[who][p] == evt) slot_mem[who][p] = '0;
          p = next_slot(p, cap);
        end
        res.count = held_count[who];
      end
    endcase
    res.mask = pending_set;
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input longint unsigned got,
                               input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  function automatic logic [31:0] pick_event();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3, 4, 5: begin
        case ($urandom_range(0, 5))
          0: return 32'h0000_0001;
          1: return 32'h8000_0000;
          2: return 32'hA5A5_5A5A;
          3: return 32'h5A5A_A5A5;
          4: return 32'h0000_FFFF;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_actor();
    if ($urandom_range(0, 1) == 0) return 3'($urandom_range(0, 2));
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic queue_request(input peqb_pkg::action_t act, input logic [2:0] who,
                               input logic [31:0] evt);
    request_t rq;
    rq.act   = act;
    rq.actor = who;
    rq.evt   = evt;
    request_backlog.push_back(rq);
  endtask

  task automatic wait_bank_idle();
    while (!(request_backlog.size() == 0 && requests_accepted == requests_driven &&
             expected_results.size() == 0))
      @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // empty every queue and walk its pointers back to slot 0 so a new capacity is safe
  task automatic drain_and_align_queues();
    int total;
    int a;
    int n;
    int cap;
    wait_bank_idle();
    total = 0;
    for (a = 0; a < peqb_pkg::ACTORS; a++) total += int'(held_count[a]);
    for (n = 0; n < total; n++)
      queue_request(peqb_pkg::ACT_TAKE, 3'($urandom_range(0, 7)), pick_event());
    wait_bank_idle();
    cap = effective_capacity(capacity_reg);
    for (a = 0; a < peqb_pkg::ACTORS; a++) begin
      if (head_ptr[a] != 4'd0) begin
        for (n = 0; n < cap - int'(head_ptr[a]); n++) begin
          queue_request(peqb_pkg::ACT_POST, a[2:0], pick_event());
          queue_request(peqb_pkg::ACT_TAKE, 3'($urandom_range(0, 7)), pick_event());
        end
      end
    end
    wait_bank_idle();
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      advance_queue_bank(peqb_pkg::action_t'(in_tuser), in_tdata[2:0], in_tdata[34:3]);
      requests_accepted <= requests_accepted + 1;
    end
  end

  always @(negedge clk) begin : request_driver
    request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && requests_accepted != requests_driven) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      gap_left  <= gap_left - 1;
      in_tvalid <= 1'b0;
    end else if (request_backlog.size() > 0) begin
      nxt = request_backlog.pop_front();
      in_tvalid       <= 1'b1;
      in_tuser        <= nxt.act;
      in_tdata        <= {5'b0, nxt.evt, nxt.actor};
      requests_driven <= requests_driven + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        case ($urandom_range(0, 3))
          0: gap_left <= 0;
          1: gap_left <= $urandom_range(8, 24);
          default: gap_left <= $urandom_range(1, 6);
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= (stall_left % 16 >= 10);
    endcase
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h status %0d", out_tdata, out_tuser));
      end else begin
        want = expected_results.pop_front();
        compare_field("event_out", out_tdata[31:0], want.ev);
        compare_field("actor_out", out_tdata[34:32], want.actor);
        compare_field("entry_count", out_tdata[39:35], want.count);
        compare_field("pending_mask", out_tdata[47:40], want.mask);
        compare_field("status", out_tuser, want.status);
      end
    end
  end

  initial begin : stimulus
    logic [4:0]        capacity_plan [7];
    int                ph;
    int                n;
    int                r;
    peqb_pkg::action_t act;
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tuser          = peqb_pkg::ACT_POST;
    out_tready        = 1'b0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    requests_driven   = 0;
    requests_accepted = 0;
    mismatch_count    = 0;
    burst_left        = 4;
    gap_left          = 0;
    stall_left        = 0;
    stall_mode        = 0;
    pending_set       = '0;
    capacity_reg      = 5'(peqb_pkg::CAP_RESET);
    for (n = 0; n < peqb_pkg::ACTORS; n++) begin
      head_ptr[n]   = '0;
      tail_ptr[n]   = '0;
      held_count[n] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tiny capacity so full, drop and wrap show up quickly
    write_capacity(5'd2);
    queue_request(peqb_pkg::ACT_TAKE,   3'd5, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_POST,   3'd0, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_POST,   3'd0, 32'hFFFF_FFFF);
    queue_request(peqb_pkg::ACT_POST,   3'd0, 32'h0000_0001);
    queue_request(peqb_pkg::ACT_INSERT, 3'd0, 32'hA5A5_5A5A);
    queue_request(peqb_pkg::ACT_REMOVE, 3'd0, 32'hA5A5_5A5A);
    queue_request(peqb_pkg::ACT_TAKE,   3'd7, 32'hFFFF_FFFF);
    queue_request(peqb_pkg::ACT_TAKE,   3'd0, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_TAKE,   3'd0, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_INSERT, 3'd7, 32'hFFFF_FFFF);
    queue_request(peqb_pkg::ACT_POST,   3'd7, 32'h1234_5678);
    queue_request(peqb_pkg::ACT_INSERT, 3'd7, 32'hDEAD_BEEF);
    queue_request(peqb_pkg::ACT_POST,   3'd3, 32'h8000_0000);
    queue_request(peqb_pkg::ACT_TAKE,   3'd0, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_REMOVE, 3'd5, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_REMOVE, 3'd7, 32'hFFFF_FFFF);
    queue_request(peqb_pkg::ACT_TAKE,   3'd2, 32'h5A5A_A5A5);
    queue_request(peqb_pkg::ACT_TAKE,   3'd4, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_TAKE,   3'd6, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_POST,   3'd6, 32'h7FFF_FFFF);
    queue_request(peqb_pkg::ACT_INSERT, 3'd6, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_REMOVE, 3'd6, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_TAKE,   3'd1, 32'h0000_0000);
    queue_request(peqb_pkg::ACT_TAKE,   3'd1, 32'h0000_0000);

    capacity_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9, 5'd3};
    capacity_plan[5] = 5'($urandom_range(2, 15));
    for (ph = 0; ph < 7; ph++) begin
      drain_and_align_queues();
      write_capacity(capacity_plan[ph]);
      for (n = 0; n < 80; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) act = peqb_pkg::ACT_POST;
        else if (r < 60) act = peqb_pkg::ACT_INSERT;
        else if (r < 85) act = peqb_pkg::ACT_TAKE;
        else act = peqb_pkg::ACT_REMOVE;
        queue_request(act, pick_actor(), pick_event());
      end
    end

    wait_bank_idle();
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("PASS prioritized_event_queue_bank");
    end else begin
      $display("FAIL prioritized_event_queue_bank");
    end
    $finish;
  end

endmodule
